/* rtl/bssa_pkg.sv */
// Shared types, constants and helper functions for the bitmap slab sub-allocator.
// Depends on nothing; imported by bitmap_slab_sub_allocator.
package bssa_pkg;

    // Occupancy map of one block: one bit per plane.
    localparam int unsigned PLANES = 8;
    localparam logic [7:0] FULL_MAP = 8'hFF;

    // Count of checkouts held saturates here.
    localparam logic [10:0] HELD_MAX = 11'd2047;

    // Operation codes of an input item.
    localparam logic OP_CHECKOUT = 1'b0;
    localparam logic OP_RELEASE  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_BLOCK_LIMIT = 1'b0;
    localparam logic CFG_TILES       = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REL,
        ST_SCAN,
        ST_COMMIT,
        ST_DONE
    } t_state;

    // Mask of a run of (1 << size_log2) planes starting at plane sub.
    // Bits above plane 7 are dropped; a run of eight planes covers the whole map.
    function automatic logic [7:0] run_mask(input logic [1:0] size_log2,
                                            input logic [2:0] sub);
        logic [15:0] w;
        if (size_log2 == 2'd3) begin
            w = {8'h00, FULL_MAP};
        end else begin
            w = ((16'd1 << (4'd1 << size_log2)) - 16'd1) << sub;
        end
        return w[7:0];
    endfunction

    // Number of occupied planes in a map.
    function automatic logic [3:0] ones(input logic [7:0] map);
        logic [3:0] n;
        n = 4'd0;
        for (int b = 0; b < PLANES; b++) begin
            n = n + 4'(map[b]);
        end
        return n;
    endfunction

    // First free, naturally aligned run: {found, sub}.
    function automatic logic [3:0] find_run(input logic [7:0] map,
                                            input logic [1:0] size_log2);
        logic [3:0] res;
        logic [2:0] align;
        res   = 4'd0;
        align = (3'd1 << size_log2) - 3'd1;
        // Walk downward so that the lowest fitting start wins.
        for (int s = PLANES - 1; s >= 0; s--) begin
            if (((3'(s) & align) == 3'd0) &&
                ((map & run_mask(size_log2, 3'(s))) == 8'h00)) begin
                res = {1'b1, 3'(s)};
            end
        end
        return res;
    endfunction

endpackage

/* rtl/bitmap_slab_sub_allocator.sv */
// Bitmap slab sub-allocator: top level with the occupancy memory and its sequencer.
// Depends on bssa_pkg for state type, constants and mask helpers.
//
//   Channel   Direction  Handshake                Payload
//   in        input      i_in_valid / o_in_stall  i_opcode, i_size_log2, i_block_index,
//                                                 i_sub_offset
//   out       output     o_out_valid / i_out_stall o_accepted, o_granted_block,
//                                                 o_granted_sub, o_plane_offset,
//                                                 o_outstanding
//   cfg       input      i_cfg_we                 i_cfg_index, i_cfg_data
//
// A checkout scans the opened blocks, reading one occupancy byte per cycle through the
// single read port of the map memory, then writes back the block that it grants.
// A release reads, modifies and writes back, then hands off the result.
// Reset clears the control state only; map entries beyond the opened count are never
// read, and a block is written in full when it is opened, so no clearing pass is needed.
// A stalled result waits in the output register while the next item is accepted; that
// item finishes once the register is free.
module bitmap_slab_sub_allocator
    import bssa_pkg::*;
#(
    parameter int unsigned BLOCKS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [1:0]  i_size_log2,
    input  logic [6:0]  i_block_index,
    input  logic [2:0]  i_sub_offset,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_accepted,
    output logic [6:0]  o_granted_block,
    output logic [2:0]  o_granted_sub,
    output logic [34:0] o_plane_offset,
    output logic [10:0] o_outstanding,
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int unsigned AW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int unsigned OW = $clog2(BLOCKS + 1);

    // Configuration registers.
    logic [7:0]  r_block_limit;
    logic [31:0] r_tiles;

    // Allocator state outside the memory.
    logic [OW-1:0] r_opened;
    logic [10:0]   r_held;

    // Captured input item.
    logic       r_op;
    logic [1:0] r_size;
    logic [6:0] r_blk;
    logic [2:0] r_sub;
    logic       r_rel_ok;

    // Sequencer.
    t_state r_state;
    t_state n_state;

    // Scan bookkeeping.
    logic [OW-1:0] r_rd_idx;
    logic          r_chk_vld;
    logic [AW-1:0] r_chk_idx;
    logic          r_found;
    logic [AW-1:0] r_pick_idx;
    logic [2:0]    r_pick_sub;
    logic [3:0]    r_pick_fill;
    logic [7:0]    r_pick_map;

    // Staged result and output register.
    logic        r_res_acc;
    logic [6:0]  r_res_blk;
    logic [2:0]  r_res_sub;
    logic [34:0] r_res_off;
    logic [10:0] r_res_outst;
    logic        r_out_vld;
    logic        r_o_acc;
    logic [6:0]  r_o_blk;
    logic [2:0]  r_o_sub;
    logic [34:0] r_o_off;
    logic [10:0] r_o_outst;

    // Occupancy memory: one write port, one registered read port.
    logic [7:0]    r_occ_mem [BLOCKS];
    logic [7:0]    r_rd_data;
    logic          mem_re;
    logic [AW-1:0] mem_ra;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;

    // Combinational helpers.
    logic            in_xfer;
    logic            out_free;
    logic            scan_issue;
    logic            in_rel_ok;
    logic            can_open;
    logic            grant;
    logic [3:0]      chk_run;
    logic [3:0]      chk_fill;
    logic [AW+6:0]   in_blk_ext;
    logic [AW+6:0]   blk_ext;
    logic [AW+6:0]   gblk_ext;
    logic [AW-1:0]   gblk_idx;
    logic [2:0]      gsub;
    logic [10:0]     held_dec;
    logic [10:0]     held_inc;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_vld || !i_out_stall;
    assign in_blk_ext = {{AW{1'b0}}, i_block_index};
    assign blk_ext    = {{AW{1'b0}}, r_blk};
    assign in_rel_ok  = (i_opcode == OP_RELEASE) &&
                        (32'(i_block_index) < 32'(r_opened));
    assign scan_issue = (r_state == ST_SCAN) && (r_rd_idx < r_opened);
    assign can_open   = (32'(r_opened) < 32'(r_block_limit)) &&
                        (32'(r_opened) < BLOCKS);
    assign grant      = r_found || can_open;
    assign gblk_idx   = r_found ? r_pick_idx : r_opened[AW-1:0];
    assign gblk_ext   = {7'd0, gblk_idx};
    assign gsub       = r_found ? r_pick_sub : 3'd0;
    assign held_dec   = (r_held != 11'd0) ? (r_held - 11'd1) : r_held;
    assign held_inc   = (r_held < HELD_MAX) ? (r_held + 11'd1) : r_held;

    // Per-block check of the byte returned by the scan read.
    assign chk_run  = find_run(r_rd_data, r_size);
    assign chk_fill = ones(r_rd_data);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = (i_opcode == OP_RELEASE) ? ST_REL : ST_SCAN;
                end
            end
            ST_REL:    n_state = ST_DONE;
            ST_SCAN: begin
                if (!scan_issue && !r_chk_vld) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Memory controls and input stall.
    always_comb begin
        o_in_stall = 1'b1;
        mem_re     = 1'b0;
        mem_ra     = r_rd_idx[AW-1:0];
        mem_we     = 1'b0;
        mem_wa     = blk_ext[AW-1:0];
        mem_wd     = r_rd_data & ~run_mask(r_size, r_sub);
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                mem_re     = i_in_valid && in_rel_ok;
                mem_ra     = in_blk_ext[AW-1:0];
            end
            ST_REL: begin
                mem_we = r_rel_ok;
            end
            ST_SCAN: begin
                mem_re = scan_issue;
            end
            ST_COMMIT: begin
                mem_we = grant;
                mem_wa = gblk_idx;
                mem_wd = r_found ? (r_pick_map | run_mask(r_size, r_pick_sub))
                                 : run_mask(r_size, 3'd0);
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Occupancy memory.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_occ_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_occ_mem[mem_ra];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_limit <= 8'd100;
            r_tiles       <= 32'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BLOCK_LIMIT: r_block_limit <= i_cfg_data[7:0];
                CFG_TILES:       r_tiles       <= i_cfg_data;
                default:         r_tiles       <= r_tiles;
            endcase
        end
    end

    // Sequencer and allocator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_opened  <= '0;
            r_held    <= 11'd0;
            r_chk_vld <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_rel_ok <= in_rel_ok;
                        r_found  <= 1'b0;
                        r_rd_idx <= '0;
                    end
                end
                ST_REL: begin
                    if (r_rel_ok) begin
                        r_held <= held_dec;
                    end
                end
                ST_SCAN: begin
                    // Issue one read per cycle and check the byte that comes back.
                    r_chk_vld <= scan_issue;
                    r_chk_idx <= r_rd_idx[AW-1:0];
                    if (scan_issue) begin
                        r_rd_idx <= r_rd_idx + OW'(1);
                    end
                    if (r_chk_vld && chk_run[3] &&
                        (!r_found || chk_fill > r_pick_fill)) begin
                        r_found     <= 1'b1;
                        r_pick_idx  <= r_chk_idx;
                        r_pick_sub  <= chk_run[2:0];
                        r_pick_fill <= chk_fill;
                        r_pick_map  <= r_rd_data;
                    end
                end
                ST_COMMIT: begin
                    if (!r_found && can_open) begin
                        r_opened <= r_opened + OW'(1);
                    end
                    if (grant) begin
                        r_held <= held_inc;
                    end
                end
                default: begin
                    r_chk_vld <= 1'b0;
                end
            endcase
        end
    end

    // Capture of the input item.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op   <= i_opcode;
            r_size <= i_size_log2;
            r_blk  <= i_block_index;
            r_sub  <= i_sub_offset;
        end
    end

    // Result staging.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_REL) begin
            r_res_acc   <= r_rel_ok;
            r_res_blk   <= 7'd0;
            r_res_sub   <= 3'd0;
            r_res_off   <= 35'd0;
            r_res_outst <= r_rel_ok ? held_dec : r_held;
        end else if (r_state == ST_COMMIT && r_op == OP_CHECKOUT) begin
            r_res_acc   <= grant;
            r_res_blk   <= grant ? gblk_ext[6:0] : 7'd0;
            r_res_sub   <= grant ? gsub : 3'd0;
            r_res_off   <= grant ? ({32'd0, gsub} * {3'd0, r_tiles}) : 35'd0;
            r_res_outst <= grant ? held_inc : r_held;
        end
    end

    // Output register: loaded when the staged result is ready and the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_vld <= 1'b1;
        end else if (r_out_vld && !i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_o_acc   <= r_res_acc;
            r_o_blk   <= r_res_blk;
            r_o_sub   <= r_res_sub;
            r_o_off   <= r_res_off;
            r_o_outst <= r_res_outst;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_accepted      = r_o_acc;
    assign o_granted_block = r_o_blk;
    assign o_granted_sub   = r_o_sub;
    assign o_plane_offset  = r_o_off;
    assign o_outstanding   = r_o_outst;

endmodule

/* tb/sv/slab_grant_checker.sv */
`timescale 1ns / 1ps
// Result checker for the bitmap slab sub-allocator: watches the item, result and register ports,
// keeps its own copy of the occupancy maps and compares every result transfer in order.
// Depends on bssa_pkg for the operation codes, register indexes and the count limit.
module slab_grant_checker
    import bssa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Item channel as seen on the block's ports.
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_opcode,
    input  logic [1:0]  i_size_log2,
    input  logic [6:0]  i_block_index,
    input  logic [2:0]  i_sub_offset,
    // Result channel as seen on the block's ports.
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_accepted,
    input  logic [6:0]  i_granted_block,
    input  logic [2:0]  i_granted_sub,
    input  logic [34:0] i_plane_offset,
    input  logic [10:0] i_outstanding,
    // Register writes.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Status for the test top.
    output int          o_fail_count,
    output int          o_pending,
    output int          o_granted,
    output int          o_refused,
    output int          o_released,
    output int          o_ignored,
    output int          o_opened
);

    localparam int unsigned BLOCK_COUNT = 128;
    localparam int          REPORT_LIMIT = 10;

    typedef struct packed {
        logic        accepted;
        logic [6:0]  blk;
        logic [2:0]  sub;
        logic [34:0] offset;
        logic [10:0] held;
    } t_grant_result;

    // Shadow state of the allocator.
    logic [7:0]    occ_map [BLOCK_COUNT];
    int unsigned   open_count;
    logic [10:0]   held_now;
    logic [7:0]    limit_reg;
    logic [31:0]   tiles_reg;
    t_grant_result expected_grants[$];
    int            fail_total;
    int            n_granted, n_refused, n_released, n_ignored;

    // Planes covered by a run; a run of eight planes always covers the whole map.
    function automatic logic [7:0] span_of(input logic [1:0] size_log2, input logic [2:0] first);
        int unsigned planes;
        logic [7:0]  m;
        planes = 1 << size_log2;
        for (int b = 0; b < 8; b++) begin
            m[b] = (b >= first) && (b < first + planes);
        end
        if (size_log2 == 2'd3) begin
            m = 8'hFF;
        end
        return m;
    endfunction

    // Applies one item to the shadow state and returns the result it must produce.
    function automatic t_grant_result predict_grant(input logic op, input logic [1:0] sz,
                                                    input logic [6:0] blk, input logic [2:0] sub);
        t_grant_result r;
        int unsigned   cap, planes, pick, pick_sub, pick_fill, fill;
        bit            found;
        r = '0;
        planes = 1 << sz;
        if (op == OP_RELEASE) begin
            // Releases of unopened blocks leave everything untouched.
            if (blk < open_count) begin
                occ_map[blk] &= ~span_of(sz, sub);
                if (held_now != 11'd0) begin
                    held_now--;
                end
                r.accepted = 1'b1;
            end
        end else begin
            cap = (limit_reg > BLOCK_COUNT) ? BLOCK_COUNT : limit_reg;
            found = 1'b0;
            pick = 0;
            pick_sub = 0;
            pick_fill = 0;
            // Fullest fitting block wins; the lowest index keeps a tie.
            for (int i = 0; i < open_count; i++) begin
                for (int s = 0; s + planes <= 8; s += planes) begin
                    if ((occ_map[i] & span_of(sz, 3'(s))) == 8'h00) begin
                        fill = $countones(occ_map[i]);
                        if (!found || fill > pick_fill) begin
                            found = 1'b1;
                            pick = i;
                            pick_sub = s;
                            pick_fill = fill;
                        end
                        break;
                    end
                end
            end
            // Nothing fits: open the next block if the limit allows.
            if (!found && open_count < cap) begin
                pick = open_count;
                pick_sub = 0;
                open_count++;
                found = 1'b1;
            end
            if (found) begin
                occ_map[pick] |= span_of(sz, 3'(pick_sub));
                if (held_now != HELD_MAX) begin
                    held_now++;
                end
                r.accepted = 1'b1;
                r.blk = 7'(pick);
                r.sub = 3'(pick_sub);
                r.offset = 35'(64'(pick_sub) * 64'(tiles_reg));
            end
        end
        r.held = held_now;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        if (fail_total < REPORT_LIMIT) begin
            $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
        end
        fail_total++;
    endtask

    // Track every transfer at the clock edge and compare results against the oldest prediction.
    always @(posedge i_clk) begin
        t_grant_result want, got;
        if (!i_rst_n) begin
            for (int i = 0; i < BLOCK_COUNT; i++) begin
                occ_map[i] = 8'h00;
            end
            open_count = 0;
            held_now = 11'd0;
            limit_reg = 8'd100;
            tiles_reg = 32'd1;
            expected_grants.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_BLOCK_LIMIT) begin
                    limit_reg = i_cfg_data[7:0];
                end else begin
                    tiles_reg = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = predict_grant(i_opcode, i_size_log2, i_block_index, i_sub_offset);
                expected_grants.push_back(want);
                if (i_opcode == OP_CHECKOUT) begin
                    if (want.accepted) n_granted++;
                    else n_refused++;
                end else begin
                    if (want.accepted) n_released++;
                    else n_ignored++;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                got = {i_accepted, i_granted_block, i_granted_sub, i_plane_offset, i_outstanding};
                if (expected_grants.size() == 0) begin
                    report_mismatch("result with no item outstanding", 0, got);
                end else begin
                    want = expected_grants.pop_front();
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", want.accepted, got.accepted);
                    if (got.blk !== want.blk)
                        report_mismatch("granted_block", want.blk, got.blk);
                    if (got.sub !== want.sub)
                        report_mismatch("granted_sub", want.sub, got.sub);
                    if (got.offset !== want.offset)
                        report_mismatch("plane_offset", want.offset, got.offset);
                    if (got.held !== want.held)
                        report_mismatch("outstanding", want.held, got.held);
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_grants.size();
        o_granted    <= n_granted;
        o_refused    <= n_refused;
        o_released   <= n_released;
        o_ignored    <= n_ignored;
        o_opened     <= open_count;
    end

endmodule

/* tb/sv/bitmap_slab_sub_allocator_test.sv */
`timescale 1ns / 1ps
// Test top for the bitmap slab sub-allocator: clock, reset, stimulus and the verdict.
// Depends on bssa_pkg, the block itself and slab_grant_checker, which does all the checking.
module bitmap_slab_sub_allocator_test;
    import bssa_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct {
        logic [6:0] blk;
        logic [2:0] sub;
        logic [1:0] size;
    } t_run;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_opcode;
    logic [1:0]  i_size_log2;
    logic [6:0]  i_block_index;
    logic [2:0]  i_sub_offset;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_accepted;
    logic [6:0]  o_granted_block;
    logic [2:0]  o_granted_sub;
    logic [34:0] o_plane_offset;
    logic [10:0] o_outstanding;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;

    int fail_count, pending, n_granted, n_refused, n_released, n_ignored, blocks_open;
    int stall_left, free_left, idle_cycles, setting_count;

    // Runs granted so far, used to build well-formed releases.
    t_run       held_runs[$];
    logic [2:0] issued_kind[$];

    bitmap_slab_sub_allocator dut (.*);

    slab_grant_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_size_log2    (i_size_log2),
        .i_block_index  (i_block_index),
        .i_sub_offset   (i_sub_offset),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_accepted     (o_accepted),
        .i_granted_block(o_granted_block),
        .i_granted_sub  (o_granted_sub),
        .i_plane_offset (o_plane_offset),
        .i_outstanding  (o_outstanding),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_granted      (n_granted),
        .o_refused      (n_refused),
        .o_released     (n_released),
        .o_ignored      (n_ignored),
        .o_opened       (blocks_open)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result-side stalls alternate with stall-free stretches of varying length.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (free_left > 0) begin
                free_left--;
            end else begin
                stall_left = pick_gap();
                free_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                         : $urandom_range(0, 6);
            end
        end
    end

    // Pair each result with the kind of item that caused it and record granted runs.
    always @(posedge i_clk) begin
        logic [2:0] kind;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            issued_kind.push_back({i_opcode, i_size_log2});
        end
        if (i_rst_n && o_out_valid && !i_out_stall && issued_kind.size() != 0) begin
            kind = issued_kind.pop_front();
            if (kind[2] == OP_CHECKOUT && o_accepted) begin
                held_runs.push_back('{o_granted_block, o_granted_sub, kind[1:0]});
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any transfer.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("bitmap_slab_sub_allocator_test: FAIL");
        $finish;
    end

    // Offers one item and returns at the edge where its transfer happens.
    task automatic send_item(input logic op, input logic [1:0] sz,
                             input logic [6:0] blk, input logic [2:0] sub);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_size_log2   <= sz;
        i_block_index <= blk;
        i_sub_offset  <= sub;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Holds off new items until every result is back, then lets the block settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] limit, input logic [31:0] tiles);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BLOCK_LIMIT;
        i_cfg_data  <= {24'd0, limit};
        @(posedge i_clk);
        i_cfg_index <= CFG_TILES;
        i_cfg_data  <= tiles;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        setting_count++;
    endtask

    // Checkouts, releases of granted runs, and a little noise of arbitrary releases.
    task automatic random_item(input int co_pct, input int wide_pct);
        int   r, pick;
        t_run run;
        r = $urandom_range(0, 99);
        if (r < co_pct) begin
            send_item(OP_CHECKOUT,
                      ($urandom_range(0, 99) < wide_pct) ? 2'd3 : 2'($urandom_range(0, 3)),
                      7'($urandom), 3'($urandom));
        end else if (r < 94 && held_runs.size() != 0) begin
            pick = $urandom_range(0, held_runs.size() - 1);
            run = held_runs[pick];
            held_runs.delete(pick);
            send_item(OP_RELEASE, run.size, run.blk, run.sub);
        end else begin
            send_item(OP_RELEASE, 2'($urandom),
                      $urandom_range(0, 1) ? 7'($urandom_range(0, 15)) : 7'($urandom),
                      3'($urandom));
        end
    endtask

    task automatic run_phase(input logic [7:0] limit, input logic [31:0] tiles,
                             input int count, input int co_pct, input int wide_pct);
        set_config(limit, tiles);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) == 0) begin
                drain_results();
            end
            random_item(co_pct, wide_pct);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_opcode      = OP_CHECKOUT;
        i_size_log2   = 2'd0;
        i_block_index = 7'd0;
        i_sub_offset  = 3'd0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_BLOCK_LIMIT;
        i_cfg_data    = 32'd0;
        setting_count = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on the reset settings: release before anything is opened.
        send_item(OP_RELEASE, 2'd0, 7'd0, 3'd0);
        // Fill block 0 with runs of one, two and four planes, then force new blocks open.
        send_item(OP_CHECKOUT, 2'd0, 7'd127, 3'd7);
        send_item(OP_CHECKOUT, 2'd1, 7'd0, 3'd0);
        send_item(OP_CHECKOUT, 2'd2, 7'd0, 3'd0);
        send_item(OP_CHECKOUT, 2'd0, 7'd0, 3'd0);
        send_item(OP_CHECKOUT, 2'd3, 7'd0, 3'd0);
        send_item(OP_CHECKOUT, 2'd0, 7'd0, 3'd0);
        send_item(OP_CHECKOUT, 2'd1, 7'd0, 3'd0);
        // An eight-plane release clears everything whatever the offset.
        send_item(OP_RELEASE, 2'd3, 7'd0, 3'd7);
        // A run reaching past plane 7 loses its upper bits.
        send_item(OP_RELEASE, 2'd2, 7'd1, 3'd6);
        // The fullest fitting block must win over an empty one.
        send_item(OP_CHECKOUT, 2'd0, 7'd0, 3'd0);
        send_item(OP_RELEASE, 2'd3, 7'd1, 3'd0);
        send_item(OP_CHECKOUT, 2'd2, 7'd0, 3'd0);
        // Release of the highest block index, never opened.
        send_item(OP_RELEASE, 2'd1, 7'd127, 3'd3);
        // More releases than checkouts held: the count must stop at zero.
        for (int k = 0; k < 7; k++) begin
            send_item(OP_RELEASE, 2'd3, 7'd0, 3'($urandom));
        end

        // Zero block limit with the widest plane stride: fill what is open, then fail.
        set_config(8'd0, 32'hFFFF_FFFF);
        send_item(OP_CHECKOUT, 2'd0, 7'd0, 3'd0);
        send_item(OP_CHECKOUT, 2'd3, 7'd0, 3'd0);
        send_item(OP_CHECKOUT, 2'd3, 7'd0, 3'd0);
        send_item(OP_CHECKOUT, 2'd3, 7'd0, 3'd0);
        send_item(OP_CHECKOUT, 2'd0, 7'd0, 3'd0);

        // Random part over several settings; the second pushes toward all blocks open.
        run_phase(8'd6, $urandom, 180, 60, 10);
        run_phase(8'd255, 32'hFFFF_FFFF, 200, 90, 85);
        run_phase(8'd128, $urandom, 220, 50, 10);
        run_phase(8'd1, 32'd0, 120, 55, 10);
        run_phase(8'd100, $urandom, 130, 55, 15);

        drain_results();
        $display("Covered %0d granted and %0d refused checkouts, %0d applied and %0d ignored releases,",
                 n_granted, n_refused, n_released, n_ignored);
        $display("over %0d register settings with up to %0d blocks opened.",
                 setting_count, blocks_open);
        if (fail_count == 0 && pending == 0) begin
            $display("bitmap_slab_sub_allocator_test: PASS");
        end else begin
            $display("bitmap_slab_sub_allocator_test: FAIL");
        end
        $finish;
    end

endmodule
